/* rtl/core/ctl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_pkg: shared types and constants of the client table
// Field widths, operation and status codes, and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package ctl_pkg;

	// fixed field widths of the item and result
	localparam int OP_W   = 4;
	localparam int IDX_W  = 7;
	localparam int IP_W   = 32;
	localparam int PORT_W = 16;
	localparam int STAT_W = 2;
	localparam int FIDX_W = 6;
	localparam int CNT_W  = 7;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 4'd0,
		OP_POP    = 4'd1,
		OP_INSERT = 4'd2,
		OP_ERASE  = 4'd3,
		OP_SET    = 4'd4,
		OP_READ   = 4'd5,
		OP_FIND   = 4'd6,
		OP_CLEAR  = 4'd7,
		OP_RESIZE = 4'd8
	} op_t;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_ERR      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic cap;     // capture the input item
		logic step;    // run one sweep iteration
		logic commit;  // apply the update and load the result register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic err;       // operation is rejected
		logic sweep;     // operation walks over entries
		logic last;      // current sweep iteration is the final one
		logic out_busy;  // result register holds a result not yet taken
	} ctl_sts_t;

endpackage
`default_nettype wire

/* rtl/core/ctl_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctl_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/ctl_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_dp: client table datapath
// Holds the item, the entry count, the sweep pointer, the entry RAM with its
// move and compare stage, and the result register.
// ----------------------------------------------------------------------------
module ctl_dp #(
	parameter int DEPTH = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ctl_pkg::ctl_cmd_t           cmd,
	output ctl_pkg::ctl_sts_t                sts,
	input  wire logic [ctl_pkg::OP_W-1:0]    op,
	input  wire logic [ctl_pkg::IDX_W-1:0]   index,
	input  wire logic [ctl_pkg::IP_W-1:0]    key_ip,
	input  wire logic [ctl_pkg::PORT_W-1:0]  key_port,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [ctl_pkg::STAT_W-1:0]       status,
	output logic [ctl_pkg::IP_W-1:0]         read_ip,
	output logic [ctl_pkg::PORT_W-1:0]       read_port,
	output logic [ctl_pkg::FIDX_W-1:0]       found_index,
	output logic [ctl_pkg::CNT_W-1:0]        entry_count,
	output logic                             is_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > ctl_pkg::IDX_W) ? CW : ctl_pkg::IDX_W) + 1;
	localparam int EW = ctl_pkg::IP_W + ctl_pkg::PORT_W;

	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_MOVE,
		PEND_CMP
	} pend_t;

	logic [ctl_pkg::OP_W-1:0]   op_q;
	logic [ctl_pkg::IDX_W-1:0]  idx_q;
	logic [ctl_pkg::IP_W-1:0]   ip_q;
	logic [ctl_pkg::PORT_W-1:0] port_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              cnt_nxt;
	logic [AW-1:0]              ptr_q;
	logic [AW-1:0]              ptr_init;
	pend_t                      pend_s1;
	logic [AW-1:0]              pend_addr_s1;
	logic                       found_q;
	logic [AW-1:0]              fidx_q;
	logic                       err;
	logic                       sweep;
	logic                       last;
	logic [XW-1:0]              idx_x;
	logic [XW-1:0]              cnt_x;
	logic [XW-1:0]              ptr_x;
	logic [XW-1:0]              dep_x;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [EW-1:0]              ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [EW-1:0]              ram_rdata;
	logic                       out_valid_q;
	logic [ctl_pkg::STAT_W-1:0] status_q;
	logic [ctl_pkg::IP_W-1:0]   read_ip_q;
	logic [ctl_pkg::PORT_W-1:0] read_port_q;
	logic [ctl_pkg::FIDX_W-1:0] found_index_q;
	logic [ctl_pkg::CNT_W-1:0]  entry_count_q;
	logic                       is_empty_q;

	// widen operands for range compares
	assign idx_x = XW'(idx_q);
	assign cnt_x = XW'(count_q);
	assign ptr_x = XW'(ptr_q);
	assign dep_x = XW'(DEPTH);

	// capture the item on transfer
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= op;
			idx_q  <= index;
			ip_q   <= key_ip;
			port_q <= key_port;
		end
	end

	// first sweep position of each walking operation
	always_comb begin
		unique case (op)
			ctl_pkg::OP_INSERT, ctl_pkg::OP_RESIZE: ptr_init = AW'(count_q);
			ctl_pkg::OP_ERASE, ctl_pkg::OP_READ:    ptr_init = AW'(index);
			default:                                ptr_init = '0;
		endcase
	end

	// range and capacity checks
	always_comb begin
		unique case (op_q)
			ctl_pkg::OP_PUSH:   err = (cnt_x >= dep_x);
			ctl_pkg::OP_POP:    err = 1'b0;
			ctl_pkg::OP_INSERT: err = (idx_x > cnt_x) || (cnt_x >= dep_x);
			ctl_pkg::OP_ERASE,
			ctl_pkg::OP_SET,
			ctl_pkg::OP_READ:   err = (idx_x >= cnt_x);
			ctl_pkg::OP_FIND,
			ctl_pkg::OP_CLEAR:  err = 1'b0;
			ctl_pkg::OP_RESIZE: err = (idx_x > dep_x);
			default:            err = 1'b1;
		endcase
	end

	// sweep extent: whether to walk at all, and where to stop
	always_comb begin
		unique case (op_q)
			ctl_pkg::OP_INSERT: begin
				sweep = (cnt_x > idx_x);
				last  = (ptr_x == idx_x + XW'(1));
			end
			ctl_pkg::OP_ERASE: begin
				sweep = (cnt_x > idx_x + XW'(1));
				last  = (ptr_x + XW'(2) == cnt_x);
			end
			ctl_pkg::OP_FIND: begin
				sweep = (cnt_x != '0);
				last  = (ptr_x + XW'(1) == cnt_x);
			end
			ctl_pkg::OP_RESIZE: begin
				sweep = (idx_x > cnt_x);
				last  = (ptr_x + XW'(1) == idx_x);
			end
			ctl_pkg::OP_READ: begin
				sweep = 1'b1;
				last  = 1'b1;
			end
			default: begin
				sweep = 1'b0;
				last  = 1'b1;
			end
		endcase
	end

	assign sts.err      = err;
	assign sts.sweep    = sweep;
	assign sts.last     = last;
	assign sts.out_busy = out_valid_q && out_stall;

	// advance the sweep pointer
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			ptr_q <= ptr_init;
		end else if (cmd.step) begin
			if (op_q == ctl_pkg::OP_INSERT) begin
				ptr_q <= ptr_q - AW'(1);
			end else begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	// read address of the current sweep iteration
	always_comb begin
		unique case (op_q)
			ctl_pkg::OP_INSERT: ram_raddr = ptr_q - AW'(1);
			ctl_pkg::OP_ERASE:  ram_raddr = ptr_q + AW'(1);
			default:            ram_raddr = ptr_q;
		endcase
	end

	// queue the move or compare that uses the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= PEND_NONE;
		end else if (cmd.step) begin
			unique case (op_q)
				ctl_pkg::OP_INSERT, ctl_pkg::OP_ERASE: pend_s1 <= PEND_MOVE;
				ctl_pkg::OP_FIND:                      pend_s1 <= PEND_CMP;
				default:                               pend_s1 <= PEND_NONE;
			endcase
		end else begin
			pend_s1 <= PEND_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			pend_addr_s1 <= ptr_q;
		end
	end

	// write port: pending move, zero fill, then the committed key
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		priority if (pend_s1 == PEND_MOVE) begin
			ram_we    = 1'b1;
			ram_waddr = pend_addr_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.step && (op_q == ctl_pkg::OP_RESIZE)) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q;
			ram_wdata = '0;
		end else if (cmd.commit && !err && ((op_q == ctl_pkg::OP_PUSH) ||
				(op_q == ctl_pkg::OP_INSERT) || (op_q == ctl_pkg::OP_SET))) begin
			ram_we    = 1'b1;
			ram_waddr = (op_q == ctl_pkg::OP_PUSH) ? AW'(count_q) : AW'(idx_q);
			ram_wdata = {ip_q, port_q};
		end else begin
			ram_we = 1'b0;
		end
	end

	ctl_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.step),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// keep the first matching position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.cap) begin
			found_q <= 1'b0;
		end else if ((pend_s1 == PEND_CMP) && !found_q && (ram_rdata == {ip_q, port_q})) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if ((pend_s1 == PEND_CMP) && !found_q && (ram_rdata == {ip_q, port_q})) begin
			fidx_q <= pend_addr_s1;
		end
	end

	// count after the operation
	always_comb begin
		cnt_nxt = count_q;
		if (!err) begin
			unique case (op_q)
				ctl_pkg::OP_PUSH, ctl_pkg::OP_INSERT: cnt_nxt = count_q + CW'(1);
				ctl_pkg::OP_POP: begin
					if (count_q != '0) begin
						cnt_nxt = count_q - CW'(1);
					end
				end
				ctl_pkg::OP_ERASE:  cnt_nxt = count_q - CW'(1);
				ctl_pkg::OP_CLEAR:  cnt_nxt = '0;
				ctl_pkg::OP_RESIZE: cnt_nxt = CW'(idx_q);
				default:            cnt_nxt = count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= cnt_nxt;
		end
	end

	// result register: load on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (err) begin
				status_q <= ctl_pkg::ST_ERR;
			end else if ((op_q == ctl_pkg::OP_FIND) && !found_q) begin
				status_q <= ctl_pkg::ST_NOTFOUND;
			end else begin
				status_q <= ctl_pkg::ST_OK;
			end
			if ((op_q == ctl_pkg::OP_READ) && !err) begin
				read_ip_q   <= ram_rdata[EW-1:ctl_pkg::PORT_W];
				read_port_q <= ram_rdata[ctl_pkg::PORT_W-1:0];
			end else begin
				read_ip_q   <= '0;
				read_port_q <= '0;
			end
			if ((op_q == ctl_pkg::OP_FIND) && found_q) begin
				found_index_q <= ctl_pkg::FIDX_W'(fidx_q);
			end else begin
				found_index_q <= '0;
			end
			entry_count_q <= ctl_pkg::CNT_W'(cnt_nxt);
			is_empty_q    <= (cnt_nxt == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_ip     = read_ip_q;
	assign read_port   = read_port_q;
	assign found_index = found_index_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;

endmodule
`default_nettype wire

/* rtl/core/ctl_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_ctrl: client table controller
// Sequences one operation: check, sweep over entries and drain the move or
// compare stage when it walks, then commit once the result register is free.
// ----------------------------------------------------------------------------
module ctl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ctl_pkg::ctl_sts_t sts,
	output ctl_pkg::ctl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SWEEP,
		S_FLUSH,
		S_DONE
	} state_t;

	state_t state_q;
	logic   in_stall_q;

	// state and stall register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q    <= S_CHECK;
						in_stall_q <= 1'b1;
					end
				end
				S_CHECK: begin
					if (sts.err || !sts.sweep) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (sts.last) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!sts.out_busy) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

	// commands to the datapath
	assign cmd.cap    = in_valid && !in_stall_q;
	assign cmd.step   = (state_q == S_SWEEP);
	assign cmd.commit = (state_q == S_DONE) && !sts.out_busy;
	assign in_stall   = in_stall_q;

endmodule
`default_nettype wire

/* rtl/core/client_table_list.sv */
`default_nettype none
// Sequencing: push, pop, set, clear and rejected operations go from check
// straight to done; insert, erase, find, read and resize walk the entries in
// the sweep state when there are any, then drain the move or compare stage in
// the flush state. A new operation is taken only once the last one commits.
// The single entry RAM port pair moves, fills or compares one entry per cycle.
// Reset: count is zero; entry contents are undefined and not cleared by reset.
// ----------------------------------------------------------------------------
// client_table_list: ordered client table with key search
// Ordered list of address and port entries with push, pop, insert, erase,
// set, read, find, clear and resize.
// ----------------------------------------------------------------------------
module client_table_list #(
	parameter int DEPTH = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [ctl_pkg::OP_W-1:0]    op,
	input  wire logic [ctl_pkg::IDX_W-1:0]   index,
	input  wire logic [ctl_pkg::IP_W-1:0]    key_ip,
	input  wire logic [ctl_pkg::PORT_W-1:0]  key_port,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [ctl_pkg::STAT_W-1:0]       status,
	output logic [ctl_pkg::IP_W-1:0]         read_ip,
	output logic [ctl_pkg::PORT_W-1:0]       read_port,
	output logic [ctl_pkg::FIDX_W-1:0]       found_index,
	output logic [ctl_pkg::CNT_W-1:0]        entry_count,
	output logic                             is_empty
);

	ctl_pkg::ctl_cmd_t cmd;
	ctl_pkg::ctl_sts_t sts;

	// operation sequencer
	ctl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table storage, checks and result register
	ctl_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.index       (index),
		.key_ip      (key_ip),
		.key_port    (key_port),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_ip     (read_ip),
		.read_port   (read_port),
		.found_index (found_index),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

endmodule
`default_nettype wire
